// File: hw/rtl/tcw_pkg.sv
// tcw_pkg: screen geometry, field widths, command codes and the control and
// status structs shared by the console writer controller and datapath.
// No dependencies.
package tcw_pkg;

   localparam int unsigned SCREEN_WIDTH  = 80;
   localparam int unsigned SCREEN_HEIGHT = 25;
   localparam int unsigned TAB_STEP      = 8;

   localparam int unsigned CELL_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int unsigned ADDR_W     = $clog2(CELL_COUNT);
   localparam int unsigned CNT_W      = $clog2(CELL_COUNT + 1);

   localparam int unsigned CMD_W   = 2;
   localparam int unsigned CHAR_W  = 8;
   localparam int unsigned CELL_W  = 16;
   localparam int unsigned INDEX_W = 11;
   localparam int unsigned ROW_W   = 5;
   localparam int unsigned COL_W   = 7;
   localparam int unsigned POS_W   = ROW_W + COL_W;
   localparam int unsigned RPOS_W  = 16;

   localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'd9;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_RETURN  = 8'd13;
   localparam logic [CELL_W-1:0] CELL_SPACE   = 16'h0020;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUT        = 2'd0,
      CMD_READ       = 2'd1,
      CMD_SET_CURSOR = 2'd2,
      CMD_BACKSPACE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      SWEEP_CLEAR_ALL = 2'd0,
      SWEEP_CLEAR_ROW = 2'd1,
      SWEEP_SCROLL    = 2'd2
   } sweep_kind_type;

   typedef struct packed {
      logic           capture;
      logic           decode;
      logic           char_step;
      logic           sweep_start;
      sweep_kind_type sweep_kind;
      logic           sweep_run;
      logic           finish;
   } ctl_type;

   typedef struct packed {
      cmd_type cmd;
      logic    need_scroll;
      logic    is_return;
      logic    sweep_done;
   } stat_type;

endpackage

// File: hw/rtl/tcw_ram.sv
// tcw_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module tcw_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/tcw_ctrl.sv
// tcw_ctrl: console writer sequencer; steps each command through decode
// and finish, a put also through character and maybe sweep. Depends on tcw_pkg.
module tcw_ctrl
   import tcw_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  stat_type stat,
   output ctl_type  ctl,
   output logic     busy,
   output logic     rsp_strobe
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_CHAR,
      S_SWEEP,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   state_type after_ff, after_in;
   logic      busy_ff;
   logic      strobe_ff;

   always_comb begin
      state_in = state_ff;
      after_in = after_ff;
      ctl      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start && !busy_ff) begin
               ctl.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            ctl.decode = 1'b1;
            if (stat.cmd == CMD_PUT) begin
               if (stat.need_scroll) begin
                  ctl.sweep_start = 1'b1;
                  ctl.sweep_kind  = SWEEP_SCROLL;
                  after_in        = S_CHAR;
                  state_in        = S_SWEEP;
               end else begin
                  state_in = S_CHAR;
               end
            end else begin
               state_in = S_FINISH;
            end
         end
         S_CHAR: begin
            ctl.char_step = 1'b1;
            if (stat.is_return) begin
               ctl.sweep_start = 1'b1;
               ctl.sweep_kind  = SWEEP_CLEAR_ROW;
               after_in        = S_FINISH;
               state_in        = S_SWEEP;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_SWEEP: begin
            ctl.sweep_run = 1'b1;
            if (stat.sweep_done) begin
               state_in = after_ff;
            end
         end
         S_FINISH: begin
            ctl.finish = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // reset starts with the screen clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_SWEEP;
         after_ff  <= S_IDLE;
         busy_ff   <= 1'b1;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         after_ff  <= after_in;
         busy_ff   <= (state_in != S_IDLE);
         strobe_ff <= ctl.finish;
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;

   a_busy_idle: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (state_ff == S_IDLE))
      else $error("busy low outside idle");

   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (start && !busy_ff) |=> (busy_ff && state_ff == S_DECODE))
      else $error("accepted transfer not decoded");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |=> !strobe_ff)
      else $error("result strobe longer than one cycle");

endmodule

// File: hw/rtl/tcw_dpath.sv
// tcw_dpath: cursor registers, request and result registers, sweep counter
// and the screen RAM of the console writer. Depends on tcw_pkg and tcw_ram.
module tcw_dpath
   import tcw_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  ctl_type            ctl,
   output stat_type           stat,
   input  logic [CMD_W-1:0]   req_cmd,
   input  logic [CHAR_W-1:0]  req_char_byte,
   input  logic [CELL_W-1:0]  req_attribute,
   input  logic [INDEX_W-1:0] req_cell_index,
   input  logic [ROW_W-1:0]   req_new_row,
   input  logic [COL_W-1:0]   req_new_col,
   input  logic               csr_write_enable,
   input  logic [CELL_W-1:0]  csr_write_data,
   output logic [CELL_W-1:0]  rsp_read_data,
   output logic [ROW_W-1:0]   rsp_cur_row,
   output logic [COL_W-1:0]   rsp_cur_col,
   output logic [RPOS_W-1:0]  rsp_cursor_pos,
   output logic               rsp_scrolled
);

   localparam logic [COL_W:0]   WIDTH_CMP  = (COL_W + 1)'(SCREEN_WIDTH);
   localparam logic [6:0]       HEIGHT_CMP = 7'(SCREEN_HEIGHT);
   localparam logic [ROW_W-1:0] ROW_LAST   = ROW_W'(SCREEN_HEIGHT - 1);
   localparam logic [COL_W-1:0] COL_WIDTH  = COL_W'(SCREEN_WIDTH);
   localparam logic [COL_W-1:0] COL_TAB    = COL_W'(TAB_STEP);
   localparam logic [POS_W-1:0] POS_WIDTH  = POS_W'(SCREEN_WIDTH);
   localparam logic [CNT_W-1:0] CNT_CELLS  = CNT_W'(CELL_COUNT);
   localparam logic [CNT_W-1:0] CNT_MOVE   = CNT_W'(CELL_COUNT - SCREEN_WIDTH);
   localparam logic [CNT_W-1:0] CNT_WIDTH  = CNT_W'(SCREEN_WIDTH);

   cmd_type            cmd_ff;
   logic [CHAR_W-1:0]  char_ff;
   logic [CELL_W-1:0]  attr_ff;
   logic [INDEX_W-1:0] index_ff;
   logic [ROW_W-1:0]   new_row_ff;
   logic [COL_W-1:0]   new_col_ff;

   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [CELL_W-1:0]  blank_ff;
   sweep_kind_type     kind_ff, kind_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               scrolled_ff, scrolled_in;
   logic               read_ok_ff, read_ok_in;

   logic [CELL_W-1:0]  rsp_data_ff;
   logic [ROW_W-1:0]   rsp_row_ff;
   logic [COL_W-1:0]   rsp_col_ff;
   logic [RPOS_W-1:0]  rsp_pos_ff;
   logic               rsp_scrolled_ff;

   logic               col_ge_w;
   logic [ROW_W-1:0]   wrap_row;
   logic [COL_W-1:0]   wrap_col;
   logic               need_scroll;
   logic               col_lt_w;
   logic               row_lt_h;
   logic [COL_W-1:0]   col_dec;
   logic [POS_W-1:0]   row_base;
   logic [POS_W-1:0]   pos_cur;
   logic [POS_W-1:0]   pos_bs;
   logic               idx_ok;
   logic               bs_ok;
   logic               sweep_done;

   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr;
   logic [CELL_W-1:0]  ram_wdata;
   logic               ram_re;
   logic [ADDR_W-1:0]  ram_raddr;
   logic [CELL_W-1:0]  ram_q;

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELL_COUNT)
   ) u_screen (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_q)
   );

   always_comb begin
      col_ge_w    = ({1'b0, col_ff} >= WIDTH_CMP);
      wrap_row    = col_ge_w ? (row_ff + 1'b1) : row_ff;
      wrap_col    = col_ge_w ? (col_ff - COL_WIDTH) : col_ff;
      need_scroll = ({2'b00, wrap_row} >= HEIGHT_CMP);
      col_lt_w    = ({1'b0, col_ff} < WIDTH_CMP);
      row_lt_h    = ({2'b00, row_ff} < HEIGHT_CMP);
      col_dec     = (col_ff != '0) ? (col_ff - 1'b1) : col_ff;
      row_base    = POS_W'(row_ff) * POS_WIDTH;
      pos_cur     = row_base + POS_W'(col_ff);
      pos_bs      = row_base + POS_W'(col_dec);
      idx_ok      = (32'(index_ff) < 32'(CELL_COUNT));
      bs_ok       = (32'(pos_bs) < 32'(CELL_COUNT));
      case (kind_ff)
         SWEEP_CLEAR_ALL: sweep_done = (cnt_ff == CNT_CELLS - 1'b1);
         SWEEP_CLEAR_ROW: sweep_done = (cnt_ff == CNT_WIDTH - 1'b1);
         SWEEP_SCROLL:    sweep_done = (cnt_ff == CNT_CELLS);
         default:         sweep_done = 1'b1;
      endcase
   end

   assign stat.cmd         = cmd_ff;
   assign stat.need_scroll = need_scroll;
   assign stat.is_return   = (char_ff == CHAR_RETURN);
   assign stat.sweep_done  = sweep_done;

   always_comb begin
      row_in      = row_ff;
      col_in      = col_ff;
      kind_in     = kind_ff;
      cnt_in      = cnt_ff;
      scrolled_in = scrolled_ff;
      read_ok_in  = read_ok_ff;
      ram_we      = 1'b0;
      ram_waddr   = '0;
      ram_wdata   = '0;
      ram_re      = 1'b0;
      ram_raddr   = '0;

      if (ctl.decode) begin
         scrolled_in = 1'b0;
         read_ok_in  = 1'b0;
         case (cmd_ff)
            CMD_PUT: begin
               row_in      = need_scroll ? ROW_LAST : wrap_row;
               col_in      = wrap_col;
               scrolled_in = need_scroll;
            end
            CMD_READ: begin
               ram_re     = idx_ok;
               ram_raddr  = ADDR_W'(index_ff);
               read_ok_in = idx_ok;
            end
            CMD_SET_CURSOR: begin
               row_in = new_row_ff;
               col_in = new_col_ff;
            end
            CMD_BACKSPACE: begin
               col_in    = col_dec;
               ram_we    = bs_ok;
               ram_waddr = ADDR_W'(pos_bs);
               ram_wdata = blank_ff | CELL_SPACE;
            end
            default: begin
               row_in = row_ff;
            end
         endcase
      end

      if (ctl.char_step) begin
         case (char_ff)
            CHAR_NEWLINE: begin
               row_in = row_ff + 1'b1;
               col_in = '0;
            end
            CHAR_RETURN: begin
               col_in = '0;
            end
            CHAR_TAB: begin
               col_in = col_ff + COL_TAB;
            end
            default: begin
               if (col_lt_w && row_lt_h) begin
                  ram_we    = 1'b1;
                  ram_waddr = ADDR_W'(pos_cur);
                  ram_wdata = attr_ff | CELL_W'(char_ff);
                  col_in    = col_ff + 1'b1;
               end
            end
         endcase
      end

      if (ctl.sweep_start) begin
         kind_in = ctl.sweep_kind;
         cnt_in  = '0;
      end

      if (ctl.sweep_run) begin
         cnt_in = cnt_ff + 1'b1;
         case (kind_ff)
            SWEEP_CLEAR_ALL: begin
               ram_we    = 1'b1;
               ram_waddr = ADDR_W'(cnt_ff);
            end
            SWEEP_CLEAR_ROW: begin
               ram_we    = 1'b1;
               ram_waddr = ADDR_W'(row_base + POS_W'(cnt_ff));
            end
            SWEEP_SCROLL: begin
               // read one row ahead, write back the cell read in the last cycle
               ram_re    = (cnt_ff < CNT_MOVE);
               ram_raddr = ADDR_W'(cnt_ff + CNT_WIDTH);
               ram_we    = (cnt_ff != '0);
               ram_waddr = ADDR_W'(cnt_ff - 1'b1);
               ram_wdata = (cnt_ff <= CNT_MOVE) ? ram_q : '0;
            end
            default: begin
               ram_we = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff   <= '0;
         col_ff   <= '0;
         blank_ff <= '0;
         kind_ff  <= SWEEP_CLEAR_ALL;
         cnt_ff   <= '0;
      end else begin
         row_ff  <= row_in;
         col_ff  <= col_in;
         kind_ff <= kind_in;
         cnt_ff  <= cnt_in;
         if (csr_write_enable) begin
            blank_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      scrolled_ff <= scrolled_in;
      read_ok_ff  <= read_ok_in;
      if (ctl.capture) begin
         cmd_ff     <= cmd_type'(req_cmd);
         char_ff    <= req_char_byte;
         attr_ff    <= req_attribute;
         index_ff   <= req_cell_index;
         new_row_ff <= req_new_row;
         new_col_ff <= req_new_col;
      end
      if (ctl.finish) begin
         rsp_data_ff     <= read_ok_ff ? ram_q : '0;
         rsp_row_ff      <= row_ff;
         rsp_col_ff      <= col_ff;
         rsp_pos_ff      <= RPOS_W'(pos_cur);
         rsp_scrolled_ff <= scrolled_ff;
      end
   end

   assign rsp_read_data  = rsp_data_ff;
   assign rsp_cur_row    = rsp_row_ff;
   assign rsp_cur_col    = rsp_col_ff;
   assign rsp_cursor_pos = rsp_pos_ff;
   assign rsp_scrolled   = rsp_scrolled_ff;

   a_write_range: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (32'(ram_waddr) < 32'(CELL_COUNT)))
      else $error("screen write off the screen");

endmodule

// File: hw/rtl/text_console_writer_core.sv
// text_console_writer_core: top level of the text console writer.
// Depends on tcw_pkg, tcw_ctrl, tcw_dpath and tcw_ram.
//
// A command is taken on a rising edge with start high and busy low; the
// req_ ports are sampled on that edge. Commands: put character, read cell,
// set cursor, backspace. Each command gives exactly one result on the rsp_
// ports, valid for the single cycle in which rsp_strobe is high; the
// receiver cannot stall and must take it then.
// A read, set cursor or backspace steps through the decode and finish
// states, a put also through the character state; rsp_strobe is registered
// from the finish state. The next command can be taken in the strobe cycle.
// A put that scrolls adds a sweep that copies each cell up a row through
// the screen RAM's single read and write port and clears the bottom row.
// A carriage return adds a sweep that clears the cursor's row.
// csr_write_data is loaded into the blank attribute when csr_write_enable
// is high; write it only while the block is idle.
// After reset busy stays high while a sweep clears every cell of the
// screen RAM (standard 80 by 25 geometry) to zero.
module text_console_writer_core
   import tcw_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [CMD_W-1:0]   req_cmd,
   input  logic [CHAR_W-1:0]  req_char_byte,
   input  logic [CELL_W-1:0]  req_attribute,
   input  logic [INDEX_W-1:0] req_cell_index,
   input  logic [ROW_W-1:0]   req_new_row,
   input  logic [COL_W-1:0]   req_new_col,
   output logic               rsp_strobe,
   output logic [CELL_W-1:0]  rsp_read_data,
   output logic [ROW_W-1:0]   rsp_cur_row,
   output logic [COL_W-1:0]   rsp_cur_col,
   output logic [RPOS_W-1:0]  rsp_cursor_pos,
   output logic               rsp_scrolled,
   input  logic               csr_write_enable,
   input  logic [CELL_W-1:0]  csr_write_data
);

   ctl_type  ctl;
   stat_type stat;

   tcw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .stat       (stat),
      .ctl        (ctl),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   tcw_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .stat             (stat),
      .req_cmd          (req_cmd),
      .req_char_byte    (req_char_byte),
      .req_attribute    (req_attribute),
      .req_cell_index   (req_cell_index),
      .req_new_row      (req_new_row),
      .req_new_col      (req_new_col),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_read_data    (rsp_read_data),
      .rsp_cur_row      (rsp_cur_row),
      .rsp_cur_col      (rsp_cur_col),
      .rsp_cursor_pos   (rsp_cursor_pos),
      .rsp_scrolled     (rsp_scrolled)
   );

endmodule
